@@ rtl/tdsl_pkg.sv @@
// Shared types and constants of the teleop delta soft limiter.
// Used by the divider, the lane and the top level; depends on nothing.
package tdsl_pkg;

    localparam int AXES        = 3;
    localparam int X_FRAC      = 28;
    localparam int GAIN_FRAC   = 8;
    localparam int TERMS       = 12;
    localparam int QUOT_W      = 32;
    localparam int DIVIDEND_W  = 68;
    localparam int DIVISOR_W   = 36;

    localparam logic [31:0] TWO_LOG2E_Q30 = 32'd3098164009;
    localparam logic [31:0] LN2_Q32       = 32'd2977044472;
    localparam logic [32:0] Q32_ONE       = 33'h1_0000_0000;
    localparam logic [16:0] W_ONE         = 17'd65536;

    localparam logic [15:0] GAIN_RESET   = 16'd1280;
    localparam logic [24:0] PLIM_RESET   = 25'd838861;
    localparam logic [25:0] RLIM_RESET   = 26'd5033165;
    localparam logic [16:0] WEIGHT_RESET = 17'd58982;

    typedef enum logic [1:0] {
        CFG_GAIN   = 2'd0,
        CFG_PLIM   = 2'd1,
        CFG_RLIM   = 2'd2,
        CFG_WEIGHT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] gain;
        logic [25:0] limit;
        logic [16:0] weight;
    } lane_cfg_t;

endpackage

@@ rtl/tdsl_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, 32-bit quotient.
// Depends on tdsl_pkg; the caller guarantees the quotient fits 32 bits.
module tdsl_div
    import tdsl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [QUOT_W-1:0]     quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [4:0]           cnt_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] div_reg;
    logic [QUOT_W-1:0]    lo_reg;
    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   rem_sub;
    logic                 fits;

    assign rem_shift = {rem_reg, lo_reg[QUOT_W-1]};
    assign rem_sub   = rem_shift - {1'b0, div_reg};
    assign fits      = (rem_shift >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[DIVIDEND_W-1:QUOT_W];
            lo_reg  <= dividend[QUOT_W-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            lo_reg  <= {lo_reg[QUOT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

endmodule

@@ rtl/tdsl_lane.sv @@
// One limiter lane: gain, tanh soft limit and moving average for one axis.
// Depends on tdsl_pkg and tdsl_div; holds the axis average register.
module tdsl_lane
    import tdsl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               seed,
    input  logic signed [31:0] delta,
    input  lane_cfg_t          cfg,
    output logic               done,
    output logic signed [31:0] avg
);

    typedef enum logic [3:0] {
        S_IDLE, S_MULA, S_CHECK, S_DIVX, S_MULZ, S_MULW, S_TMUL, S_TGO,
        S_TDIV, S_EXP, S_FGO, S_FDIV, S_MAG, S_EMA1, S_EMA2, S_DONE
    } state_t;

    state_t             state_reg;
    logic               neg_reg;
    logic [31:0]        mag_reg;
    logic [47:0]        a_reg;
    logic [31:0]        xq_reg;
    logic [33:0]        z_reg;
    logic [31:0]        w_reg;
    logic [32:0]        acc_reg;
    logic [3:0]         k_reg;
    logic [64:0]        prod_reg;
    logic [31:0]        quot_reg;
    logic [32:0]        e_reg;
    logic [31:0]        t31_reg;
    logic signed [31:0] fresh_reg;
    logic signed [49:0] p1_reg;
    logic signed [31:0] avg_reg;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_q;
    logic                  huge;
    logic [32:0]           num;
    logic [33:0]           den;
    logic [63:0]           z_prod;
    logic [59:0]           w_prod;
    logic [57:0]           m_prod;
    logic [26:0]           lm;
    logic [5:0]            n_exp;
    logic [16:0]           w_eff;
    logic signed [50:0]    ema_sum;
    logic [35:0]           recip_k;
    logic [67:0]           recip_prod;

    assign huge   = (a_reg >= {10'd0, cfg.limit, 12'd0});
    assign num    = Q32_ONE - e_reg;
    assign den    = {1'b0, Q32_ONE} + {1'b0, e_reg};
    assign z_prod = xq_reg * TWO_LOG2E_Q30 + 64'd536870912;
    assign w_prod = {32'd0, z_reg[X_FRAC-1:0]} * {28'd0, LN2_Q32} + 60'd134217728;
    assign m_prod = {32'd0, cfg.limit} * {26'd0, t31_reg} + 58'd1073741824;
    assign lm     = m_prod[57:31];
    assign n_exp  = z_reg[33:28];
    assign w_eff  = (cfg.weight > W_ONE) ? W_ONE : cfg.weight;
    assign ema_sum = 51'(p1_reg) + $signed({1'b0, W_ONE - w_eff}) * avg_reg
                     + 51'sd32768;

    // The reciprocal ceil(2^36 / k) gives the exact floor quotient of any 32-bit numerator.
    always_comb
    begin
        case (k_reg)
            4'd2:    recip_k = 36'd34359738368;
            4'd3:    recip_k = 36'd22906492246;
            4'd4:    recip_k = 36'd17179869184;
            4'd5:    recip_k = 36'd13743895348;
            4'd6:    recip_k = 36'd11453246123;
            4'd7:    recip_k = 36'd9817068106;
            4'd8:    recip_k = 36'd8589934592;
            4'd9:    recip_k = 36'd7635497416;
            4'd10:   recip_k = 36'd6871947674;
            4'd11:   recip_k = 36'd6247225158;
            4'd12:   recip_k = 36'd5726623062;
            default: recip_k = 36'd0;
        endcase
    end

    assign recip_prod = {36'd0, prod_reg[63:32]} * {32'd0, recip_k};

    assign div_start = ((state_reg == S_CHECK) && (cfg.limit != '0) && !huge)
                       || (state_reg == S_FGO);

    always_comb
    begin
        case (state_reg)
            S_FGO:
            begin
                div_dividend = ({35'd0, num} << 31) + {35'd0, den[33:1]};
                div_divisor  = {2'd0, den};
            end
            default:
            begin
                div_dividend = {a_reg, 20'd0};
                div_divisor  = {10'd0, cfg.limit};
            end
        endcase
    end

    tdsl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            avg_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_MULA;
                    end
                end
                S_MULA:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (cfg.limit == '0)
                    begin
                        state_reg <= S_EMA1;
                    end
                    else if (huge)
                    begin
                        state_reg <= S_MAG;
                    end
                    else
                    begin
                        state_reg <= S_DIVX;
                    end
                end
                S_DIVX:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_MULZ;
                    end
                end
                S_MULZ:
                begin
                    state_reg <= S_MULW;
                end
                S_MULW:
                begin
                    state_reg <= S_TMUL;
                end
                S_TMUL:
                begin
                    state_reg <= S_TGO;
                end
                S_TGO:
                begin
                    state_reg <= S_TDIV;
                end
                S_TDIV:
                begin
                    state_reg <= (k_reg == 4'd1) ? S_EXP : S_TMUL;
                end
                S_EXP:
                begin
                    state_reg <= S_FGO;
                end
                S_FGO:
                begin
                    state_reg <= S_FDIV;
                end
                S_FDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_MAG;
                    end
                end
                S_MAG:
                begin
                    state_reg <= S_EMA1;
                end
                S_EMA1:
                begin
                    if (seed)
                    begin
                        avg_reg   <= fresh_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_EMA2;
                    end
                end
                S_EMA2:
                begin
                    avg_reg   <= ema_sum[47:16];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                neg_reg <= delta[31];
                mag_reg <= delta[31] ? 32'(-delta) : 32'(delta);
            end
            S_MULA:
            begin
                a_reg <= {16'd0, mag_reg} * {32'd0, cfg.gain};
            end
            S_CHECK:
            begin
                fresh_reg <= '0;
                t31_reg   <= 32'h8000_0000;
            end
            S_DIVX:
            begin
                xq_reg <= div_q;
            end
            S_MULZ:
            begin
                z_reg <= z_prod[63:30];
            end
            S_MULW:
            begin
                w_reg   <= w_prod[59:28];
                acc_reg <= Q32_ONE;
                k_reg   <= 4'(TERMS);
            end
            S_TMUL:
            begin
                prod_reg <= {33'd0, w_reg} * {32'd0, acc_reg};
            end
            S_TGO:
            begin
                quot_reg <= (k_reg == 4'd1) ? prod_reg[63:32] : recip_prod[67:36];
            end
            S_TDIV:
            begin
                acc_reg <= Q32_ONE - {1'b0, quot_reg};
                k_reg   <= k_reg - 4'd1;
            end
            S_EXP:
            begin
                e_reg <= (n_exp >= 6'd40) ? 33'd0 : (acc_reg >> n_exp);
            end
            S_FDIV:
            begin
                t31_reg <= div_q;
            end
            S_MAG:
            begin
                fresh_reg <= neg_reg ? -$signed({5'd0, lm}) : $signed({5'd0, lm});
            end
            S_EMA1:
            begin
                p1_reg <= $signed({1'b0, w_eff}) * fresh_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == S_DONE);
    assign avg  = avg_reg;

endmodule

@@ rtl/teleop_delta_soft_limit_ema.sv @@
// Top level: configuration registers, three position lanes and a yaw lane,
// and the merge stage that forms targets. Depends on tdsl_pkg and tdsl_lane.
//
//   channel  signals                            direction
//   in       in_valid, in_ready, current_*, delta_*  request in
//   out      out_valid, out_ready, target_*, smooth_*  request out
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  write in
//
// A request runs from acceptance to the next acceptance, with the output free, through
// two 32-step bit-serial divisions and a twelve-term series, all lanes in parallel.
// The divisions and series are skipped when a limit is zero or the argument saturates.
// Reset clears the averages and the seed flag and reloads the configuration defaults.
// A finished result waits in the output register while the next request runs; a
// second finished request holds the lanes and the input until the output is taken.
module teleop_delta_soft_limit_ema
    import tdsl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] current_x,
    input  logic signed [31:0] current_y,
    input  logic signed [31:0] current_z,
    input  logic signed [31:0] delta_x,
    input  logic signed [31:0] delta_y,
    input  logic signed [31:0] delta_z,
    input  logic signed [31:0] delta_yaw,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] target_x,
    output logic signed [31:0] target_y,
    output logic signed [31:0] target_z,
    output logic signed [31:0] smooth_dx,
    output logic signed [31:0] smooth_dy,
    output logic signed [31:0] smooth_dz,
    output logic signed [31:0] smooth_dyaw,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [15:0] gain_reg;
    logic [24:0] plim_reg;
    logic [25:0] rlim_reg;
    logic [16:0] weight_reg;
    logic        busy_reg;
    logic        seeded_reg;
    logic        out_valid_reg;
    logic [3:0]  done_mask_reg;

    logic signed [31:0] cur_reg [3];
    logic signed [31:0] target_reg [3];
    logic signed [31:0] smooth_reg [4];

    logic signed [31:0] cur_in [3];
    logic signed [31:0] delta_in [4];
    logic signed [31:0] lane_avg [4];
    logic [3:0]         lane_done;
    logic               in_accept;
    logic               all_done;
    logic               finish;
    lane_cfg_t          pos_cfg;
    lane_cfg_t          yaw_cfg;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
        begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            sat_add = s[31:0];
        end
    endfunction

    assign cur_in[0]   = current_x;
    assign cur_in[1]   = current_y;
    assign cur_in[2]   = current_z;
    assign delta_in[0] = delta_x;
    assign delta_in[1] = delta_y;
    assign delta_in[2] = delta_z;
    assign delta_in[3] = delta_yaw;

    assign pos_cfg = '{gain: gain_reg, limit: {1'b0, plim_reg}, weight: weight_reg};
    assign yaw_cfg = '{gain: 16'd1 << GAIN_FRAC, limit: rlim_reg, weight: weight_reg};

    assign in_ready  = !busy_reg;
    assign in_accept = in_valid && in_ready;
    assign all_done  = &(done_mask_reg | lane_done);
    assign finish    = busy_reg && all_done && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        if (i < AXES)
        begin : g_lane
            tdsl_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .start (in_accept),
                .seed  (!seeded_reg),
                .delta (delta_in[i]),
                .cfg   (pos_cfg),
                .done  (lane_done[i]),
                .avg   (lane_avg[i])
            );
        end
        else
        begin : g_pass
            assign lane_done[i] = 1'b1;
            assign lane_avg[i]  = '0;
        end
    end

    tdsl_lane u_yaw (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_accept),
        .seed  (1'b0),
        .delta (delta_in[3]),
        .cfg   (yaw_cfg),
        .done  (lane_done[3]),
        .avg   (lane_avg[3])
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RESET;
            plim_reg      <= PLIM_RESET;
            rlim_reg      <= RLIM_RESET;
            weight_reg    <= WEIGHT_RESET;
            busy_reg      <= 1'b0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            done_mask_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_GAIN:   gain_reg   <= cfg_data[15:0];
                    CFG_PLIM:   plim_reg   <= cfg_data[24:0];
                    CFG_RLIM:   rlim_reg   <= cfg_data[25:0];
                    CFG_WEIGHT: weight_reg <= cfg_data[16:0];
                    default:    gain_reg   <= gain_reg;
                endcase
            end
            if (in_accept)
            begin
                busy_reg      <= 1'b1;
                done_mask_reg <= '0;
            end
            else if (busy_reg)
            begin
                done_mask_reg <= done_mask_reg | lane_done;
            end
            if (finish)
            begin
                busy_reg      <= 1'b0;
                seeded_reg    <= 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cur_reg[i] <= cur_in[i];
            end
        end
        if (finish)
        begin
            for (int i = 0; i < 3; i++)
            begin
                target_reg[i] <= sat_add(cur_reg[i], lane_avg[i]);
            end
            for (int i = 0; i < 4; i++)
            begin
                smooth_reg[i] <= lane_avg[i];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign target_x    = target_reg[0];
    assign target_y    = target_reg[1];
    assign target_z    = target_reg[2];
    assign smooth_dx   = smooth_reg[0];
    assign smooth_dy   = smooth_reg[1];
    assign smooth_dz   = smooth_reg[2];
    assign smooth_dyaw = smooth_reg[3];

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> busy_reg)
        else $error("accepted request did not start the lanes");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_done[3]) |-> busy_reg)
        else $error("lane finished with no request in flight");
    a_finish_seed: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (seeded_reg && out_valid_reg && !busy_reg))
        else $error("finished request not delivered to the output register");
`endif

endmodule

@@ tb/testbench.sv @@
// Testbench for teleop_delta_soft_limit_ema: directed and random frames, checked against
// an in-bench model of the tanh soft limiter and moving average. Depends on tdsl_pkg.
`timescale 1ns / 100ps

module testbench;
    import tdsl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 1200;
    localparam int LONG_HOLD      = 3000;

    typedef struct packed {
        logic [31:0] tx, ty, tz, sx, sy, sz, syaw;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] current_x = '0, current_y = '0, current_z = '0;
    logic signed [31:0] delta_x = '0, delta_y = '0, delta_z = '0, delta_yaw = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] target_x, target_y, target_z;
    logic signed [31:0] smooth_dx, smooth_dy, smooth_dz, smooth_dyaw;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_index_t cfg_index = CFG_GAIN;
    logic [31:0] cfg_data = '0;

    frame_result_t pending_frames[$];
    int error_count = 0;
    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    logic [15:0] m_gain;
    logic [24:0] m_plim;
    logic [25:0] m_rlim;
    logic [16:0] m_weight;
    logic signed [31:0] m_avg_pos[3];
    logic signed [31:0] m_avg_yaw;
    bit m_seeded;

    teleop_delta_soft_limit_ema u_top (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint unsigned exp_neg_two(longint unsigned xq);
        longint unsigned z, n, f, w, acc;
        z = (xq * 64'd3098164009 + (64'd1 << 29)) >> 30;
        n = z >> 28;
        f = z & ((64'd1 << 28) - 1);
        w = (f * 64'd2977044472 + (64'd1 << 27)) >> 28;
        acc = 64'd1 << 32;
        for (int k = 12; k >= 1; k--)
        begin
            acc = (64'd1 << 32) - ((w * acc) >> 32) / k;
        end
        if (n >= 40)
            return 0;
        return acc >> n;
    endfunction

    function automatic longint unsigned limited_mag(longint unsigned a, longint unsigned lim,
                                                    int pre);
        longint unsigned t31, xq, e, num, den;
        if (lim == 0)
            return 0;
        if (a >= ((lim << pre) << 4))
            t31 = 64'd1 << 31;
        else
        begin
            xq = (a << (28 - pre)) / lim;
            e = exp_neg_two(xq);
            num = (64'd1 << 32) - e;
            den = (64'd1 << 32) + e;
            t31 = ((num << 31) + den / 2) / den;
        end
        return (lim * t31 + (64'd1 << 30)) >> 31;
    endfunction

    function automatic logic signed [31:0] blend(longint fresh, logic signed [31:0] old);
        longint w, v;
        w = m_weight;
        if (w > 65536)
            w = 65536;
        v = w * fresh + (65536 - w) * longint'(old) + 32768;
        return 32'(v >>> 16);
    endfunction

    function automatic logic [31:0] sat_add(logic signed [31:0] a, logic signed [31:0] b);
        longint v;
        v = longint'(a) + longint'(b);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return 32'(v);
    endfunction

    function automatic longint signed_limit(logic signed [31:0] d, longint unsigned lim,
                                            longint unsigned scale, int pre);
        longint unsigned mag;
        longint m;
        mag = (d < 0) ? longint'(-longint'(d)) : longint'(d);
        m = longint'(limited_mag(mag * scale, lim, pre));
        return (d < 0) ? -m : m;
    endfunction

    function automatic frame_result_t shape_frame(logic signed [31:0] cur[3],
                                                  logic signed [31:0] d[3],
                                                  logic signed [31:0] dyaw);
        frame_result_t r;
        logic [31:0] tgt[3];
        longint lim;
        for (int i = 0; i < 3; i++)
        begin
            lim = signed_limit(d[i], m_plim, m_gain, GAIN_FRAC);
            if (!m_seeded)
                m_avg_pos[i] = 32'(lim);
            else
                m_avg_pos[i] = blend(lim, m_avg_pos[i]);
            tgt[i] = sat_add(cur[i], m_avg_pos[i]);
        end
        m_seeded = 1'b1;
        m_avg_yaw = blend(signed_limit(dyaw, m_rlim, 1, 0), m_avg_yaw);
        r = '{tgt[0], tgt[1], tgt[2], m_avg_pos[0], m_avg_pos[1], m_avg_pos[2], m_avg_yaw};
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h", field, got, want);
        error_count++;
    endtask

    task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    always @(posedge clk)
    begin
        frame_result_t want;
        if (out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                $display("unexpected result request");
                error_count++;
            end
            else
            begin
                want = pending_frames.pop_front();
                check_field("target_x", target_x, want.tx);
                check_field("target_y", target_y, want.ty);
                check_field("target_z", target_z, want.tz);
                check_field("smooth_dx", smooth_dx, want.sx);
                check_field("smooth_dy", smooth_dy, want.sy);
                check_field("smooth_dz", smooth_dz, want.sz);
                check_field("smooth_dyaw", smooth_dyaw, want.syaw);
            end
        end
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            hold_left = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("teleop_delta_soft_limit_ema test failed");
            $finish;
        end
    end

    task automatic send_frame(logic signed [31:0] cx, cy, cz, dx, dy, dz, dyaw);
        logic signed [31:0] cur[3];
        logic signed [31:0] d[3];
        cur = '{cx, cy, cz};
        d = '{dx, dy, dz};
        in_valid <= 1'b1;
        current_x <= cx;
        current_y <= cy;
        current_z <= cz;
        delta_x <= dx;
        delta_y <= dy;
        delta_z <= dz;
        delta_yaw <= dyaw;
        do
            @(posedge clk);
        while (!in_ready);
        pending_frames.push_back(shape_frame(cur, d, dyaw));
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_GAIN:   m_gain = value[15:0];
            CFG_PLIM:   m_plim = value[24:0];
            CFG_RLIM:   m_rlim = value[25:0];
            CFG_WEIGHT: m_weight = value[16:0];
            default:
            begin
            end
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_delta();
        logic signed [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 1 << 18);
            2: v = $urandom_range(0, 1 << 22);
            3: v = $urandom_range(0, 1 << 26);
            default: v = $urandom_range(0, 3) == 0 ? 32'h7fffffff : $urandom_range(0, 255);
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    function automatic logic signed [31:0] rand_current();
        case ($urandom_range(0, 3))
            0: return 32'h7fffffff - $urandom_range(0, 1 << 20);
            1: return 32'h80000000 + $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(int count);
        for (int n = 0; n < count; n++)
            send_frame(rand_current(), rand_current(), rand_current(),
                       rand_delta(), rand_delta(), rand_delta(), rand_delta());
    endtask

    task automatic test_directed_defaults();
        send_frame(0, 0, 0, 0, 0, 0, 0);
        send_frame(1, -1, 0, 1, -1, 1, -1);
        send_frame(32'h7fffffff, 32'h80000000, 0,
                   32'h7fffffff, 32'h80000000, 32'h00100000, 32'h7fffffff);
        send_frame(32'h7fffff00, 32'h80000100, 32'h12345678,
                   32'h00040000, -32'sh00040000, 32'h00010000, 32'h80000000);
        send_frame(0, 0, 0, 32'h00002000, -32'sh00002000, 32'h00000100, 32'h00400000);
        send_frame(32'h7fffffff, 32'h80000000, 0,
                   32'h01000000, -32'sh01000000, 32'h7fffffff, -32'sh00400000);
    endtask

    task automatic test_special_settings();
        write_reg(CFG_PLIM, 0);
        write_reg(CFG_RLIM, 0);
        send_frame(5, -5, 0, 32'h00100000, 32'h80000000, 32'h7fffffff, 32'h00300000);
        write_reg(CFG_PLIM, 32'h01ffffff);
        write_reg(CFG_RLIM, 32'h03ffffff);
        write_reg(CFG_WEIGHT, 32'h1ffff);
        send_frame(0, 0, 0, 32'h00200000, -32'sh00200000, 32'h7fffffff, 32'h7fffffff);
        write_reg(CFG_GAIN, 32'hffff);
        write_reg(CFG_PLIM, 1);
        write_reg(CFG_RLIM, 1);
        write_reg(CFG_WEIGHT, 0);
        send_frame(3, 3, 3, 32'h7fffffff, 32'h80000000, 1, 32'h80000000);
        send_frame(3, 3, 3, 2, -2, 0, 17);
        write_reg(CFG_GAIN, 0);
        write_reg(CFG_PLIM, 16777216);
        write_reg(CFG_RLIM, 52707179);
        write_reg(CFG_WEIGHT, 65536);
        send_frame(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h80000000, 1, 32'h01000000);
        write_reg(CFG_GAIN, 256);
        send_frame(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h80000000, 1, 32'h01000000);
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(CFG_GAIN, $urandom_range(0, 65535));
            write_reg(CFG_PLIM, $urandom_range(1, 16777216));
            write_reg(CFG_RLIM, $urandom_range(1, 52707179));
            write_reg(CFG_WEIGHT, $urandom_range(0, 4) == 0 ? $urandom_range(65536, 131071)
                                                             : $urandom_range(0, 65536));
            send_random(100);
        end
    endtask

    task automatic test_full_output();
        write_reg(CFG_GAIN, 32'(GAIN_RESET));
        write_reg(CFG_PLIM, 32'(PLIM_RESET));
        write_reg(CFG_RLIM, 32'(RLIM_RESET));
        write_reg(CFG_WEIGHT, 32'(WEIGHT_RESET));
        long_hold_req = 1'b1;
        send_random(8);
    endtask

    task automatic test_sender_pause();
        send_random(20);
        wait_drained();
        send_random(20);
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        send_random(100);
    endtask

    initial
    begin
        m_gain = GAIN_RESET;
        m_plim = PLIM_RESET;
        m_rlim = RLIM_RESET;
        m_weight = WEIGHT_RESET;
        m_avg_pos = '{0, 0, 0};
        m_avg_yaw = 0;
        m_seeded = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_defaults();
        test_special_settings();
        test_full_output();
        test_random_settings();
        test_sender_pause();
        test_no_idle();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("teleop_delta_soft_limit_ema test passed");
        else
            $display("teleop_delta_soft_limit_ema test failed");
        $finish;
    end

endmodule
